>>> design/mrpt_pkg.sv
package mrpt_pkg;

  localparam int unsigned NUM_W       = 63;
  localparam int unsigned NUM_BASES   = 12;
  localparam int unsigned BIDX_W      = 4;
  localparam int unsigned SHIFT_W     = 6;
  localparam logic [NUM_W-1:0] SMALL_LIMIT = 63'd40;

  // witness bases, smallest first
  function automatic logic [5:0] base_of(input logic [BIDX_W-1:0] idx);
    logic [5:0] b;
    unique case (idx)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

endpackage

>>> design/mrpt_mulmod.sv
// (x * y) mod m by shift-and-add, one multiplier bit per cycle; x, y < m.
module mrpt_mulmod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mrpt_pkg::NUM_W-1:0]  x,
  input  logic [mrpt_pkg::NUM_W-1:0]  y,
  input  logic [mrpt_pkg::NUM_W-1:0]  m,
  output logic                        done,
  output logic [mrpt_pkg::NUM_W-1:0]  result
);

  localparam int unsigned W = mrpt_pkg::NUM_W;

  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] add_r, add_nxt;
  logic [W-1:0] mult_r, mult_nxt;
  logic [W-1:0] m_r, m_nxt;
  logic [W:0]   acc_sum, dbl_sum;

  assign acc_sum = {1'b0, acc_r} + {1'b0, add_r};
  assign dbl_sum = {1'b0, add_r} + {1'b0, add_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    add_nxt  = add_r;
    mult_nxt = mult_r;
    m_nxt    = m_r;
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      add_nxt  = x;
      mult_nxt = y;
      m_nxt    = m;
    end else if (busy_r) begin
      if (mult_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (mult_r[0]) begin
          acc_nxt = (acc_sum >= {1'b0, m_r}) ? W'(acc_sum - {1'b0, m_r}) : acc_sum[W-1:0];
        end
        add_nxt  = (dbl_sum >= {1'b0, m_r}) ? W'(dbl_sum - {1'b0, m_r}) : dbl_sum[W-1:0];
        mult_nxt = mult_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r  <= acc_nxt;
    add_r  <= add_nxt;
    mult_r <= mult_nxt;
    m_r    <= m_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

>>> design/miller_rabin_primality_test_unit.sv
// Deterministic Miller-Rabin primality test for 63-bit unsigned numbers.
// One number in, one verdict out (tdata bit 0: 1 = prime). Numbers up to 40
// are answered from the base list. Larger numbers run the twelve bases 2..37
// through one shared shift-and-add modular multiplier that retires one
// multiplier bit per cycle. One base needs up to about 125 products (a square
// per exponent bit, a multiply per set bit, plus the trailing squarings).
// A composite usually stops after the first base.
// The block takes one number at a time; in_tready is high only while idle.
// A base dividing the number never reaches 1 or n-1, so it is caught as a
// witness without a separate divisibility check.
module miller_rabin_primality_test_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [62:0] number_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] is_prime
);

  localparam int unsigned W = mrpt_pkg::NUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_BASE, S_POW, S_MUL1, S_MUL2, S_SQCHK, S_MUL3, S_DONE
  } state_t;

  state_t                       state_r;
  logic [W-1:0]                 n_r, d_r, pv_r, sq_r, e_r;
  logic [mrpt_pkg::SHIFT_W-1:0] s_r, r_r;
  logic [mrpt_pkg::BIDX_W-1:0]  bidx_r;
  logic                         verdict_r;
  logic                         out_valid_r, out_bit_r;
  logic                         mm_start_r, mm_start_nxt;
  logic [W-1:0]                 mm_x_r, mm_y_r;
  logic                         mm_done;
  logic [W-1:0]                 mm_res;
  logic [W-1:0]                 nm1;
  logic [W-1:0]                 in_num;
  logic                         small_hit;

  assign nm1    = n_r - W'(1);
  assign in_num = in_tdata[W-1:0];

  always_comb begin
    small_hit = 1'b0;
    for (int i = 0; i < mrpt_pkg::NUM_BASES; i++) begin
      if (in_num == W'(mrpt_pkg::base_of(mrpt_pkg::BIDX_W'(i)))) small_hit = 1'b1;
    end
  end

  // multiplier kick: issued from the states that load its operands
  assign mm_start_nxt = (state_r == S_POW && e_r != '0) ||
                        (state_r == S_MUL1 && mm_done) ||
                        (state_r == S_SQCHK && r_r < s_r);

  mrpt_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start_r),
    .x      (mm_x_r),
    .y      (mm_y_r),
    .m      (n_r),
    .done   (mm_done),
    .result (mm_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mm_start_r  <= 1'b0;
    end else begin
      mm_start_r <= mm_start_nxt;
      if (state_r != S_DONE && out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            n_r <= in_num;
            if (in_num <= mrpt_pkg::SMALL_LIMIT) begin
              verdict_r <= small_hit;
              state_r   <= S_DONE;
            end else begin
              d_r     <= in_num - W'(1);
              s_r     <= '0;
              bidx_r  <= '0;
              state_r <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (!d_r[0]) begin
            d_r <= d_r >> 1;
            s_r <= s_r + mrpt_pkg::SHIFT_W'(1);
          end else begin
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          pv_r    <= W'(1);
          sq_r    <= W'(mrpt_pkg::base_of(bidx_r));
          e_r     <= d_r;
          state_r <= S_POW;
        end
        S_POW: begin
          if (e_r == '0) begin
            if (pv_r == W'(1) || pv_r == nm1) begin
              if (bidx_r == mrpt_pkg::BIDX_W'(mrpt_pkg::NUM_BASES - 1)) begin
                verdict_r <= 1'b1;
                state_r   <= S_DONE;
              end else begin
                bidx_r  <= bidx_r + mrpt_pkg::BIDX_W'(1);
                state_r <= S_BASE;
              end
            end else begin
              r_r     <= mrpt_pkg::SHIFT_W'(1);
              state_r <= S_SQCHK;
            end
          end else if (e_r[0]) begin
            mm_x_r  <= pv_r;
            mm_y_r  <= sq_r;
            state_r <= S_MUL1;
          end else begin
            mm_x_r  <= sq_r;
            mm_y_r  <= sq_r;
            state_r <= S_MUL2;
          end
        end
        S_MUL1: begin
          if (mm_done) begin
            pv_r    <= mm_res;
            mm_x_r  <= sq_r;
            mm_y_r  <= sq_r;
            state_r <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mm_done) begin
            sq_r    <= mm_res;
            e_r     <= e_r >> 1;
            state_r <= S_POW;
          end
        end
        S_SQCHK: begin
          if (r_r < s_r) begin
            mm_x_r  <= pv_r;
            mm_y_r  <= pv_r;
            state_r <= S_MUL3;
          end else begin
            verdict_r <= 1'b0;   // witness found
            state_r   <= S_DONE;
          end
        end
        S_MUL3: begin
          if (mm_done) begin
            pv_r <= mm_res;
            r_r  <= r_r + mrpt_pkg::SHIFT_W'(1);
            if (mm_res == nm1) begin
              if (bidx_r == mrpt_pkg::BIDX_W'(mrpt_pkg::NUM_BASES - 1)) begin
                verdict_r <= 1'b1;
                state_r   <= S_DONE;
              end else begin
                bidx_r  <= bidx_r + mrpt_pkg::BIDX_W'(1);
                state_r <= S_BASE;
              end
            end else begin
              state_r <= S_SQCHK;
            end
          end
        end
        S_DONE: begin
          // hold until the previous verdict has been transferred
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_bit_r   <= verdict_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
